// ===== hdl/dcdq_pkg.sv =====
// ----------------------------------------------------------------------------
// dcdq_pkg
// Shared types and constants of the display command decoder and event queue.
// ----------------------------------------------------------------------------
package dcdq_pkg;

  localparam int QUEUE_DEPTH = 512;
  localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [5:0] NUM_CELLS  = 6'd40;
  localparam logic [5:0] HALF_CELLS = 6'd20;

  localparam logic [7:0] BYTE_CLEAR      = 8'h01;
  localparam logic [7:0] BYTE_ROW0_FIRST = 8'h40;
  localparam logic [7:0] BYTE_ROW0_LAST  = 8'h53;
  localparam logic [7:0] BYTE_ROW1_FIRST = 8'h60;
  localparam logic [7:0] BYTE_ROW1_LAST  = 8'h73;
  localparam logic [7:0] BYTE_PRINT_MIN  = 8'h20;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_POP   = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [5:0] cell_pos;
    logic [7:0] char_code;
    kind_t      kind;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } q_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/dcdq_queue.sv =====
// ----------------------------------------------------------------------------
// dcdq_queue
// Circular event queue in one synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module dcdq_queue import dcdq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_req_t  req,
  output q_stat_t stat,
  output entry_t  rd_data
);

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;

  always_comb begin
    head_next = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
    tail_next = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
  end

  assign stat.full  = (tail_next == head);
  assign stat.empty = (tail == head);

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail] <= req.entry;
    end
    if (req.pop) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (req.push) begin
        tail <= tail_next;
      end
      if (req.pop) begin
        head <= head_next;
      end
    end
  end

endmodule

// ===== hdl/display_command_decoder_queue_top.sv =====
// ----------------------------------------------------------------------------
// display_command_decoder_queue_top
// Decodes bytes written to a 40-cell display controller and queues events.
// ----------------------------------------------------------------------------
// Input stream: tuser selects the request (0 = controller byte write,
// 1 = pop oldest event), tdata carries the byte. Every request gives exactly
// one result on the output stream.
// A byte write updates the cursor, pushes a clear, move or write event unless
// it is a control byte below 0x20 other than clear, and answers in the next
// cycle with only the dropped flag set if the queue was full. A pop answers
// with the oldest event (event_valid = 1) or all zeros when the queue is
// empty. A write or an empty pop loads the result register; a pop that
// returns an event first reads the queue memory into its read register, then
// loads the result. One request is in flight at a time, so the input takes
// one write per cycle while the output does not stall, but no request while
// a pop reads the memory. The result register holds a result until taken;
// while the receiver stalls, tready stays low. Reset clears the cursor, the
// queue pointers and the output valid flag; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module display_command_decoder_queue_top import dcdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] event_valid, [6:1] cell_position,
                                      // [14:7] char_code, [15] dropped
  output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t     state;
  logic [5:0] cursor;
  logic [5:0] cursor_next;
  logic       gen_event;
  entry_t     ev;
  q_req_t     q_req;
  q_stat_t    q_stat;
  entry_t     rd_data;
  logic       out_free;
  logic       accept;
  logic [7:0] b;

  logic       res_valid;
  logic [5:0] res_cell;
  logic [7:0] res_char;
  kind_t      res_kind;
  logic       res_drop;

  assign b        = s_axis_tdata;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    gen_event    = 1'b1;
    cursor_next  = cursor;
    ev.cell_pos  = cursor;
    ev.char_code = 8'd0;
    ev.kind      = KIND_WRITE;
    if (b == BYTE_CLEAR) begin
      cursor_next = 6'd0;
      ev.cell_pos = 6'd0;
      ev.kind     = KIND_CLEAR;
    end else if (b >= BYTE_ROW0_FIRST && b <= BYTE_ROW0_LAST) begin
      cursor_next = 6'(b - BYTE_ROW0_FIRST);
      ev.cell_pos = cursor_next;
      ev.kind     = KIND_MOVE;
    end else if (b >= BYTE_ROW1_FIRST && b <= BYTE_ROW1_LAST) begin
      cursor_next = 6'(b - BYTE_ROW1_FIRST) + HALF_CELLS;
      ev.cell_pos = cursor_next;
      ev.kind     = KIND_MOVE;
    end else if (b >= BYTE_PRINT_MIN) begin
      ev.char_code = b;
      cursor_next  = (cursor == NUM_CELLS - 6'd1) ? 6'd0 : cursor + 6'd1;
    end else begin
      gen_event = 1'b0;
    end
  end

  assign q_req.push  = accept && (s_axis_tuser == OP_WRITE) && gen_event && !q_stat.full;
  assign q_req.pop   = accept && (s_axis_tuser == OP_POP) && !q_stat.empty;
  assign q_req.entry = ev;

  dcdq_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .req     (q_req),
    .stat    (q_stat),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cursor        <= 6'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == OP_WRITE) begin
              cursor        <= cursor_next;
              m_axis_tvalid <= 1'b1;
            end else if (q_stat.empty) begin
              m_axis_tvalid <= 1'b1;
            end else begin
              m_axis_tvalid <= 1'b0;
              state         <= ST_READ;
            end
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end
        ST_READ: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      res_valid <= 1'b0;
      res_cell  <= 6'd0;
      res_char  <= 8'd0;
      res_kind  <= KIND_WRITE;
      res_drop  <= (s_axis_tuser == OP_WRITE) && gen_event && q_stat.full;
    end else if (state == ST_READ && out_free) begin
      res_valid <= 1'b1;
      res_cell  <= rd_data.cell_pos;
      res_char  <= rd_data.char_code;
      res_kind  <= rd_data.kind;
      res_drop  <= 1'b0;
    end
  end

  assign m_axis_tdata = {res_drop, res_char, res_cell, res_valid};
  assign m_axis_tuser = res_kind;

endmodule

// ===== hdl/dcdq_checker.sv =====
// ----------------------------------------------------------------------------
// dcdq_checker
// Port-level checks of the display command decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dcdq_checker import dcdq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_drop_no_event: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[15] |-> !m_axis_tdata[0])
    else $error("dropped flag on a popped event");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |->
      m_axis_tdata[14:1] == 14'd0 && m_axis_tuser == KIND_WRITE)
    else $error("payload set on a result without event");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[6:1] < NUM_CELLS)
    else $error("cell position out of range");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind display_command_decoder_queue_top dcdq_checker u_dcdq_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the display command decoder and event queue.
// ----------------------------------------------------------------------------
// Sends controller byte writes and pops over the request stream, keeps its
// own model of the cursor and the event queue, and compares each result
// field by field against the oldest expected one. The run covers every byte
// class, cursor wrap, a full queue with dropped events, drains to empty,
// and a long output stall that backs up the request side.
// ----------------------------------------------------------------------------
module tb;
  import dcdq_pkg::*;

  typedef struct packed {
    logic       valid;
    logic [5:0] cell_pos;
    logic [7:0] char_code;
    kind_t      kind;
    logic       dropped;
  } display_result_t;

  class event_scoreboard;
    logic [5:0]      cursor;
    entry_t          queued_events[$];
    display_result_t expected_results[$];
    int              errors;

    function new();
      cursor = '0;
      errors = 0;
    endfunction

    function void note_request(logic op, logic [7:0] b);
      display_result_t r;
      entry_t          e;
      logic            has_event;
      r = '0;
      e = '0;
      has_event = 1'b0;
      if (op == OP_POP) begin
        if (queued_events.size() != 0) begin
          e = queued_events.pop_front();
          r.valid     = 1'b1;
          r.cell_pos  = e.cell_pos;
          r.char_code = e.char_code;
          r.kind      = e.kind;
        end
      end else if (b == BYTE_CLEAR) begin
        cursor = '0;
        e.kind = KIND_CLEAR;
        has_event = 1'b1;
      end else if (b >= BYTE_ROW0_FIRST && b <= BYTE_ROW0_LAST) begin
        cursor = 6'(b - BYTE_ROW0_FIRST);
        e.cell_pos = cursor;
        e.kind = KIND_MOVE;
        has_event = 1'b1;
      end else if (b >= BYTE_ROW1_FIRST && b <= BYTE_ROW1_LAST) begin
        cursor = 6'(b - BYTE_ROW1_FIRST) + HALF_CELLS;
        e.cell_pos = cursor;
        e.kind = KIND_MOVE;
        has_event = 1'b1;
      end else if (b >= BYTE_PRINT_MIN) begin
        e.cell_pos  = cursor;
        e.char_code = b;
        e.kind      = KIND_WRITE;
        has_event   = 1'b1;
        cursor = (cursor == NUM_CELLS - 6'd1) ? 6'd0 : 6'(cursor + 6'd1);
      end
      if (has_event) begin
        if (queued_events.size() >= QUEUE_DEPTH - 1) r.dropped = 1'b1;
        else queued_events.push_back(e);
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] data, logic [1:0] user);
      display_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %h", data, user);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("event_valid", 8'(exp_r.valid), 8'(data[0]));
      compare_field("cell_position", 8'(exp_r.cell_pos), 8'(data[6:1]));
      compare_field("char_code", exp_r.char_code, data[14:7]);
      compare_field("event_kind", 8'(exp_r.kind), 8'(user));
      compare_field("dropped", 8'(exp_r.dropped), 8'(data[15]));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] data_byte
  logic        s_axis_tuser;    // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [0] event_valid, [6:1] cell_position,
                                // [14:7] char_code, [15] dropped
  logic [1:0]  m_axis_tuser;    // [1:0] event_kind

  logic            hold_off_req;
  int              burst_left;
  event_scoreboard sb = new();

  display_command_decoder_queue_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
    end
  end

  task automatic send_request(input logic op, input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 9) >= 3) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return BYTE_CLEAR;
    if (sel < 13) return 8'($urandom_range(0, BYTE_PRINT_MIN - 1));
    if (sel < 28) return 8'($urandom_range(BYTE_ROW0_FIRST, BYTE_ROW0_LAST));
    if (sel < 43) return 8'($urandom_range(BYTE_ROW1_FIRST, BYTE_ROW1_LAST));
    return 8'($urandom_range(BYTE_PRINT_MIN, 255));
  endfunction

  task automatic run_mix(input int count, input int pop_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < pop_pct) send_request(OP_POP, 8'($urandom));
      else send_request(OP_WRITE, pick_byte());
    end
  endtask

  initial begin
    logic [7:0] directed_bytes [16];
    directed_bytes = '{8'h00, 8'h1F, 8'h20, 8'hFF, 8'h01, 8'h40, 8'h53, 8'h3F,
                       8'h54, 8'h5F, 8'h60, 8'h74, 8'h73, 8'h7E, 8'h7F, 8'h80};
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= OP_WRITE;
    s_axis_tdata  <= '0;
    hold_off_req  <= 1'b0;
    burst_left    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_POP, 8'h00);
    foreach (directed_bytes[i]) send_request(OP_WRITE, directed_bytes[i]);
    send_request(OP_POP, 8'hFF);
    repeat (7) send_request(OP_POP, 8'h00);

    run_mix(600, 45);
    // fill the queue past full, starting with one long hold-off on the output side
    hold_off_req <= 1'b1;
    run_mix(600, 0);
    run_mix(560, 100);
    run_mix(200, 50);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    int stretch;
    int mode;
    int hold_cycles;
    bit long_hold_done;
    long_hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_off_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clk);
      end else begin
        stretch = $urandom_range(1, 48);
        mode    = $urandom_range(0, 2);
        repeat (stretch) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

endmodule

// ===== filelist.f =====
hdl/dcdq_pkg.sv
hdl/dcdq_queue.sv
hdl/display_command_decoder_queue_top.sv
hdl/dcdq_checker.sv
tb/sv/tb.sv
